/* rtl/core/riseu_pkg.sv */
`timescale 1ns / 1ps

package riseu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [7:0] OP_NOP   = 8'd0;
    localparam logic [7:0] OP_ADD   = 8'd1;
    localparam logic [7:0] OP_SUB   = 8'd2;
    localparam logic [7:0] OP_CLR   = 8'd3;
    localparam logic [7:0] OP_XOR   = 8'd4;
    localparam logic [7:0] OP_OR    = 8'd5;
    localparam logic [7:0] OP_NOT   = 8'd6;
    localparam logic [7:0] OP_AND   = 8'd7;
    localparam logic [7:0] OP_ASL   = 8'd8;
    localparam logic [7:0] OP_ASR   = 8'd9;
    localparam logic [7:0] OP_LSL   = 8'd10;
    localparam logic [7:0] OP_LSR   = 8'd11;
    localparam logic [7:0] OP_COPY  = 8'd12;
    localparam logic [7:0] OP_LCH   = 8'd14;
    localparam logic [7:0] OP_LCL   = 8'd15;
    localparam logic [7:0] OP_LOAD  = 8'd16;
    localparam logic [7:0] OP_STORE = 8'd17;
    localparam logic [7:0] OP_MULT  = 8'd18;
    localparam logic [7:0] OP_DIV   = 8'd19;
    localparam logic [7:0] OP_POW   = 8'd20;
    localparam logic [7:0] OP_MOD   = 8'd21;
    localparam logic [7:0] OP_ADDI  = 8'd22;
    localparam logic [7:0] OP_INC   = 8'd23;
    localparam logic [7:0] OP_DEC   = 8'd24;
    localparam logic [7:0] OP_LI    = 8'd25;
    localparam logic [7:0] OP_BGT   = 8'd26;
    localparam logic [7:0] OP_JAL   = 8'd32;
    localparam logic [7:0] OP_JR    = 8'd33;
    localparam logic [7:0] OP_BEQ   = 8'd34;
    localparam logic [7:0] OP_BNE   = 8'd35;
    localparam logic [7:0] OP_J     = 8'd36;
    localparam logic [7:0] OP_HALT  = 8'd255;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } t_mdu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] q;
        logic [31:0] rem;
    } t_mdu_rsp;

endpackage

/* rtl/core/riseu_if.sv */
`timescale 1ns / 1ps

interface riseu_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] mem_addr;
    logic [31:0] mem_word;

    modport source(output valid, req_type, mem_addr, mem_word, input ready);
    modport sink(input valid, req_type, mem_addr, mem_word, output ready);
endinterface

interface riseu_rsp_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic               reg_written;
    logic [4:0]         dest_reg;
    logic signed [31:0] dest_value;
    logic               flag_negative;
    logic               flag_is_zero;
    logic               flag_overflow;
    logic               flag_carry;
    logic               halted;

    modport source(output valid, next_pc, reg_written, dest_reg, dest_value, flag_negative,
                   flag_is_zero, flag_overflow, flag_carry, halted, input ready);
    modport sink(input valid, next_pc, reg_written, dest_reg, dest_value, flag_negative,
                 flag_is_zero, flag_overflow, flag_carry, halted, output ready);
endinterface

/* rtl/core/riseu_mdu.sv */
`timescale 1ns / 1ps

// Shift-add multiplier / restoring divider (unsigned)
module riseu_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  riseu_pkg::t_mdu_req i_req,
    output riseu_pkg::t_mdu_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_div;
    logic [4:0]  r_cnt;
    logic [31:0] r_acc;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [32:0] w_trial;

    assign w_trial = {r_acc, r_x[31]} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_acc <= '0;
            r_x   <= i_req.a;
            r_y   <= i_req.b;
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[32]) begin
                    r_acc <= w_trial[31:0];
                    r_x   <= {r_x[30:0], 1'b1};
                end else begin
                    r_acc <= {r_acc[30:0], r_x[31]};
                    r_x   <= {r_x[30:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[30:0], 1'b0};
                r_y <= {1'b0, r_y[31:1]};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_div ? r_x : r_acc;
    assign o_rsp.rem  = r_acc;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("mdu start while busy");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("mdu done while busy");
`endif

endmodule

/* rtl/core/risc_instruction_execute_unit.sv */
`timescale 1ns / 1ps

// Small 32-bit RISC core, one instruction per step transfer.
// i_req (sink): req_type 0 writes mem_word to memory at mem_addr, sets pc to
//   load_base and clears halt; req_type 1 fetches, increments pc and executes unless halted.
// o_rsp (source): one transfer per request with pc, register write, flags and
//   halt state after the item.
// APB: register 0 (byte address 0) is load_base; the user must write it only
//   while idle, the block itself does not enforce this.
// Mult, and div/mod with a nonzero divisor, wait on the multiply/divide unit;
//   pow with a non-negative exponent runs up to two multiplies per exponent bit.
// One item at a time: i_req.ready is high only while idle.
// Reset (synchronous, active low) clears pc, flags, halt, load_base and the
//   register file valid bits; memory content is undefined until written.
// A stalled o_rsp holds its transfer and no new request is taken.
// Memory depth MEM_WORDS must be a power of two.
module risc_instruction_execute_unit #(
    parameter int MEM_WORDS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    riseu_req_if.sink          i_req,
    riseu_rsp_if.source        o_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready
);

    localparam int MA = $clog2(MEM_WORDS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_RA    = 4'd2;
    localparam logic [3:0] S_RB    = 4'd3;
    localparam logic [3:0] S_RC    = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_EX    = 4'd6;
    localparam logic [3:0] S_MD    = 4'd7;
    localparam logic [3:0] S_LD    = 4'd8;
    localparam logic [3:0] S_PW    = 4'd9;
    localparam logic [3:0] S_PWM1  = 4'd10;
    localparam logic [3:0] S_PWSQ  = 4'd11;
    localparam logic [3:0] S_PWM2  = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_WB2   = 4'd14;
    localparam logic [3:0] S_RESP  = 4'd15;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic        r_halt, n_halt;
    logic [3:0]  r_flags, n_flags;
    logic [15:0] r_load_base;
    logic [31:0] r_ins, n_ins;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_c, n_c;
    logic [31:0] r_r, n_r;
    logic [31:0] r_pr, n_pr;
    logic [31:0] r_base, n_base;
    logic [31:0] r_ex, n_ex;
    logic        r_wr, n_wr;
    logic [4:0]  r_dst, n_dst;
    logic [31:0] r_val, n_val;

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_mem_q;
    logic        w_mem_we;
    logic [MA-1:0] w_mem_waddr;
    logic [MA-1:0] w_mem_raddr;
    logic [31:0] w_mem_wdata;

    logic [31:0] r_rf [riseu_pkg::REG_COUNT];
    logic [riseu_pkg::REG_COUNT-1:0] r_rf_vld;
    logic [31:0] r_rf_q;
    logic        w_rf_we;
    logic [riseu_pkg::REG_AW-1:0] w_rf_waddr;
    logic [riseu_pkg::REG_AW-1:0] w_rf_raddr;

    riseu_pkg::t_mdu_req w_mdu_req;
    riseu_pkg::t_mdu_rsp w_mdu_rsp;

    logic        w_in_acc;
    logic [7:0]  w_op;
    logic [4:0]  w_ia, w_ib, w_ic;
    logic [7:0]  w_fa, w_fb;
    logic [31:0] w_shl, w_shr, w_sar;
    logic        w_big_sh;
    logic        w_an, w_bn, w_rn, w_ap, w_bp, w_rp;
    logic        w_cy_rule, w_md_ov, w_v, w_cy;

    assign w_op = r_ins[31:24];
    assign w_fa = r_ins[23:16];
    assign w_fb = r_ins[15:8];
    assign w_ia = r_ins[20:16];
    assign w_ib = r_ins[12:8];
    assign w_ic = r_ins[4:0];

    assign w_in_acc    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // configuration port
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == 1'b0) ? {16'd0, r_load_base} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= '0;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == 1'b0)) begin
            r_load_base <= i_pwdata[15:0];
        end
    end

    // main memory
    assign w_mem_raddr = (r_state == S_EX) ? r_a[MA-1:0] : r_pc[MA-1:0];
    assign w_mem_we    = (w_in_acc && (i_req.req_type == riseu_pkg::REQ_LOAD)) ||
                         ((r_state == S_EX) && (w_op == riseu_pkg::OP_STORE));
    assign w_mem_waddr = (r_state == S_EX) ? r_c[MA-1:0] : i_req.mem_addr[MA-1:0];
    assign w_mem_wdata = (r_state == S_EX) ? r_a : i_req.mem_word;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_mem_q <= r_mem[w_mem_raddr];
    end

    // register file
    always_comb begin
        case (r_state)
            S_RB:    w_rf_raddr = w_ib;
            S_RC:    w_rf_raddr = (w_op == riseu_pkg::OP_JR) ? riseu_pkg::LINK_REG : w_ic;
            default: w_rf_raddr = w_ia;
        endcase
    end

    assign w_rf_we    = (r_state == S_FIN) || (r_state == S_WB2);
    assign w_rf_waddr = (r_state == S_WB2) ? w_ia :
                        ((w_op == riseu_pkg::OP_JAL) ? riseu_pkg::LINK_REG : w_ic);

    always_ff @(posedge i_clk) begin
        if (w_rf_we) begin
            r_rf[w_rf_waddr] <= r_r;
        end
        r_rf_q <= r_rf_vld[w_rf_raddr] ? r_rf[w_rf_raddr] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (w_rf_we) begin
            r_rf_vld[w_rf_waddr] <= 1'b1;
        end
    end

    riseu_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mdu_req),
        .o_rsp   (w_mdu_rsp)
    );

    // shifter
    assign w_big_sh = (r_b[31:5] != 27'd0);
    assign w_shl    = w_big_sh ? 32'd0 : (r_a << r_b[4:0]);
    assign w_shr    = w_big_sh ? 32'd0 : (r_a >> r_b[4:0]);
    assign w_sar    = w_big_sh ? {32{r_a[31]}} : 32'($signed(r_a) >>> r_b[4:0]);

    // flags on the final result
    assign w_an = r_a[31];
    assign w_bn = r_b[31];
    assign w_rn = r_r[31];
    assign w_ap = (r_a != 32'd0) && !w_an;
    assign w_bp = (r_b != 32'd0) && !w_bn;
    assign w_rp = (r_r != 32'd0) && !w_rn;
    assign w_cy_rule = (!w_an && w_bn && !w_rn) || (w_an && !w_bn && !w_rn) || (w_an && w_bn);
    assign w_md_ov = (w_ap && w_bp && w_rn) || (w_an && w_bn && w_rn) ||
                     (w_ap && w_bn && w_rp) || (w_an && w_bp && w_rp);

    always_comb begin
        w_v  = 1'b0;
        w_cy = 1'b0;
        case (w_op)
            riseu_pkg::OP_ADD: begin
                w_v  = (w_ap && w_bp && w_rn) || (w_an && w_bn && w_rp);
                w_cy = w_cy_rule;
            end
            riseu_pkg::OP_SUB: begin
                w_v  = (w_ap && w_bn && w_rn) || (w_an && w_bp && w_rp);
                w_cy = w_cy_rule;
            end
            riseu_pkg::OP_MULT, riseu_pkg::OP_DIV: w_v = w_md_ov;
            riseu_pkg::OP_POW: begin
                w_v = w_bn || (w_ap && !w_rp) ||
                      (w_an && w_bp && !r_b[0] && w_rn) ||
                      (w_an && w_bp && r_b[0] && w_rp);
            end
            riseu_pkg::OP_ADDI: begin
                w_v  = w_ap && (w_fb != 8'd0) && w_rn;
                w_cy = w_an && !w_rn;
            end
            riseu_pkg::OP_INC: w_v = (r_a == 32'h7fffffff);
            riseu_pkg::OP_DEC: w_v = (r_a == 32'h80000000);
            default: begin
                w_v  = 1'b0;
                w_cy = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_halt  = r_halt;
        n_flags = r_flags;
        n_ins   = r_ins;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_r     = r_r;
        n_pr    = r_pr;
        n_base  = r_base;
        n_ex    = r_ex;
        n_wr    = r_wr;
        n_dst   = r_dst;
        n_val   = r_val;
        w_mdu_req.start  = 1'b0;
        w_mdu_req.is_div = 1'b0;
        w_mdu_req.a      = r_a;
        w_mdu_req.b      = r_b;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_wr  = 1'b0;
                    n_dst = '0;
                    n_val = '0;
                    if (i_req.req_type == riseu_pkg::REQ_LOAD) begin
                        n_pc    = r_load_base;
                        n_halt  = 1'b0;
                        n_state = S_RESP;
                    end else if (r_halt) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_ins   = r_mem_q;
                n_pc    = r_pc + 16'd1;
                n_state = S_RA;
            end
            S_RA: n_state = S_RB;
            S_RB: begin
                n_a     = r_rf_q;
                n_state = S_RC;
            end
            S_RC: begin
                n_b     = r_rf_q;
                n_state = S_RD;
            end
            S_RD: begin
                n_c     = r_rf_q;
                n_state = S_EX;
            end
            S_EX: begin
                n_state = S_FIN;
                case (w_op)
                    riseu_pkg::OP_ADD:  n_r = r_a + r_b;
                    riseu_pkg::OP_SUB:  n_r = r_a - r_b;
                    riseu_pkg::OP_CLR:  n_r = 32'd0;
                    riseu_pkg::OP_XOR:  n_r = r_a ^ r_b;
                    riseu_pkg::OP_OR:   n_r = r_a | r_b;
                    riseu_pkg::OP_NOT:  n_r = ~r_a;
                    riseu_pkg::OP_AND:  n_r = r_a & r_b;
                    riseu_pkg::OP_ASL, riseu_pkg::OP_LSL: n_r = w_shl;
                    riseu_pkg::OP_ASR:  n_r = w_sar;
                    riseu_pkg::OP_LSR:  n_r = w_shr;
                    riseu_pkg::OP_COPY: n_r = r_a;
                    riseu_pkg::OP_LCH:  n_r = {r_ins[23:8], r_c[15:0]};
                    riseu_pkg::OP_LCL:  n_r = {r_c[31:16], r_ins[23:8]};
                    riseu_pkg::OP_LOAD: n_state = S_LD;
                    riseu_pkg::OP_MULT: begin
                        w_mdu_req.start = 1'b1;
                        n_state         = S_MD;
                    end
                    riseu_pkg::OP_DIV, riseu_pkg::OP_MOD: begin
                        if (r_b == 32'd0) begin
                            n_r = (w_op == riseu_pkg::OP_DIV) ? 32'hffffffff : r_a;
                        end else begin
                            w_mdu_req.start  = 1'b1;
                            w_mdu_req.is_div = 1'b1;
                            w_mdu_req.a      = r_a[31] ? (32'd0 - r_a) : r_a;
                            w_mdu_req.b      = r_b[31] ? (32'd0 - r_b) : r_b;
                            n_state          = S_MD;
                        end
                    end
                    riseu_pkg::OP_POW: begin
                        if (r_b[31]) begin
                            if (r_a == 32'd1) begin
                                n_r = 32'd1;
                            end else if (r_a == 32'hffffffff) begin
                                n_r = r_b[0] ? 32'hffffffff : 32'd1;
                            end else begin
                                n_r = 32'd0;
                            end
                        end else begin
                            n_pr    = 32'd1;
                            n_base  = r_a;
                            n_ex    = r_b;
                            n_state = S_PW;
                        end
                    end
                    riseu_pkg::OP_ADDI: n_r = r_a + {24'd0, w_fb};
                    riseu_pkg::OP_INC:  n_r = r_a + 32'd1;
                    riseu_pkg::OP_DEC:  n_r = r_a - 32'd1;
                    riseu_pkg::OP_LI:   n_r = {24'd0, w_fa};
                    riseu_pkg::OP_JAL: begin
                        n_r  = {16'd0, r_pc};
                        n_pc = r_ins[15:0] + r_load_base;
                    end
                    riseu_pkg::OP_BGT: begin
                        if ($signed(r_a) > $signed(r_b)) begin
                            n_pc = {8'd0, r_ins[7:0]} + r_load_base;
                        end
                        n_state = S_RESP;
                    end
                    riseu_pkg::OP_BEQ: begin
                        if (r_a == r_b) begin
                            n_pc = {8'd0, r_ins[7:0]} + r_load_base;
                        end
                        n_state = S_RESP;
                    end
                    riseu_pkg::OP_BNE: begin
                        if (r_a != r_b) begin
                            n_pc = {8'd0, r_ins[7:0]} + r_load_base;
                        end
                        n_state = S_RESP;
                    end
                    riseu_pkg::OP_JR: begin
                        n_pc    = r_c[15:0] + r_load_base;
                        n_state = S_RESP;
                    end
                    riseu_pkg::OP_J: begin
                        n_pc    = r_ins[15:0] + r_load_base;
                        n_state = S_RESP;
                    end
                    riseu_pkg::OP_HALT: begin
                        n_halt  = 1'b1;
                        n_state = S_RESP;
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_MD: begin
                if (w_mdu_rsp.done) begin
                    case (w_op)
                        riseu_pkg::OP_DIV: n_r = (r_a[31] != r_b[31]) ?
                                                 (32'd0 - w_mdu_rsp.q) : w_mdu_rsp.q;
                        riseu_pkg::OP_MOD: n_r = r_a[31] ?
                                                 (32'd0 - w_mdu_rsp.rem) : w_mdu_rsp.rem;
                        default:           n_r = w_mdu_rsp.q;
                    endcase
                    n_state = S_FIN;
                end
            end
            S_LD: begin
                n_r     = r_mem_q;
                n_state = S_FIN;
            end
            S_PW: begin
                if (r_ex == 32'd0) begin
                    n_r     = r_pr;
                    n_state = S_FIN;
                end else begin
                    w_mdu_req.start = 1'b1;
                    w_mdu_req.a     = r_ex[0] ? r_pr : r_base;
                    w_mdu_req.b     = r_base;
                    n_state         = r_ex[0] ? S_PWM1 : S_PWM2;
                end
            end
            S_PWM1: begin
                if (w_mdu_rsp.done) begin
                    n_pr    = w_mdu_rsp.q;
                    n_state = S_PWSQ;
                end
            end
            S_PWSQ: begin
                w_mdu_req.start = 1'b1;
                w_mdu_req.a     = r_base;
                w_mdu_req.b     = r_base;
                n_state         = S_PWM2;
            end
            S_PWM2: begin
                if (w_mdu_rsp.done) begin
                    n_base  = w_mdu_rsp.q;
                    n_ex    = {1'b0, r_ex[31:1]};
                    n_state = S_PW;
                end
            end
            S_FIN: begin
                n_wr  = 1'b1;
                n_dst = w_rf_waddr;
                n_val = r_r;
                if (w_op == riseu_pkg::OP_MOD) begin
                    n_flags = {1'b0, r_r == 32'd0, 2'b00};
                end else if ((w_op != riseu_pkg::OP_LCH) && (w_op != riseu_pkg::OP_LCL) &&
                             (w_op != riseu_pkg::OP_LOAD) && (w_op != riseu_pkg::OP_LI) &&
                             (w_op != riseu_pkg::OP_JAL)) begin
                    n_flags = {w_rn, r_r == 32'd0, w_v, w_cy};
                end
                n_state = ((w_op == riseu_pkg::OP_INC) || (w_op == riseu_pkg::OP_DEC)) ?
                          S_WB2 : S_RESP;
            end
            S_WB2: n_state = S_RESP;
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins  <= n_ins;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_r    <= n_r;
        r_pr   <= n_pr;
        r_base <= n_base;
        r_ex   <= n_ex;
        r_wr   <= n_wr;
        r_dst  <= n_dst;
        r_val  <= n_val;
    end

    assign o_rsp.valid         = (r_state == S_RESP);
    assign o_rsp.next_pc       = r_pc;
    assign o_rsp.reg_written   = r_wr;
    assign o_rsp.dest_reg      = r_dst;
    assign o_rsp.dest_value    = r_val;
    assign o_rsp.flag_negative = r_flags[3];
    assign o_rsp.flag_is_zero  = r_flags[2];
    assign o_rsp.flag_overflow = r_flags[1];
    assign o_rsp.flag_carry    = r_flags[0];
    assign o_rsp.halted        = r_halt;

`ifndef ASSERT_OFF
    a_load_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_req.req_type == riseu_pkg::REQ_LOAD)) |=> (r_pc == $past(r_load_base)))
        else $error("pc not set to load base");
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.reg_written) |-> ((o_rsp.dest_reg == 5'd0) &&
        (o_rsp.dest_value == 32'sd0))) else $error("nonzero dest without write");
    a_rf_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rf_we |-> ((r_state == S_FIN) || (r_state == S_WB2)))
        else $error("register write outside writeback");
`endif

endmodule

/* tb/risc_instruction_execute_unit_tb.sv */
`timescale 1ns / 1ps

module risc_instruction_execute_unit_tb;
    import riseu_pkg::*;

    localparam int MEM_WORDS = 4096;
    localparam logic [2:0] ADDR_LOAD_BASE = 3'd0;
    localparam int STEP_ITEMS = 1200;

    typedef struct {
        bit [15:0] next_pc;
        bit        reg_written;
        bit [4:0]  dest_reg;
        bit [31:0] dest_value;
        bit        neg;
        bit        zero;
        bit        ovf;
        bit        carry;
        bit        halted;
    } core_result_t;

    class exec_scoreboard;
        bit [31:0]    regs[32];
        bit [31:0]    mem[MEM_WORDS];
        bit           written[MEM_WORDS];
        bit [15:0]    pc;
        bit [15:0]    base;
        bit           fn, fz, fv, fcy, halt;
        core_result_t pending_results[$];
        int           errors;

        function bit pos(bit [31:0] x);
            return x != 0 && !x[31];
        endfunction

        function bit [31:0] mag(bit [31:0] x);
            return x[31] ? -x : x;
        endfunction

        function bit muldiv_ovf(bit [31:0] a, bit [31:0] b, bit [31:0] r);
            return (pos(a) && pos(b) && r[31]) || (a[31] && b[31] && r[31]) ||
                   (pos(a) && b[31] && pos(r)) || (a[31] && pos(b) && pos(r));
        endfunction

        function bit sign_carry(bit [31:0] a, bit [31:0] b, bit [31:0] r);
            return (!a[31] && b[31] && !r[31]) || (a[31] && !b[31] && !r[31]) ||
                   (a[31] && b[31]);
        endfunction

        function bit [31:0] ipow(bit [31:0] bs, bit [31:0] ex);
            bit [31:0] r;
            r = 1;
            if (ex[31]) begin
                if (bs == 1) return 1;
                if (bs == '1) return ex[0] ? '1 : 32'd1;
                return 0;
            end
            while (ex != 0) begin
                if (ex[0]) r = r * bs;
                bs = bs * bs;
                ex = ex >> 1;
            end
            return r;
        endfunction

        function bit fetch_ok();
            bit [31:0] ins;
            if (halt) return 1;
            if (!written[pc % MEM_WORDS]) return 0;
            ins = mem[pc % MEM_WORDS];
            if (ins[31:24] == OP_LOAD && !written[regs[ins[20:16]] % MEM_WORDS]) return 0;
            return 1;
        endfunction

        function void note_request(bit rt, bit [15:0] addr, bit [31:0] word);
            core_result_t res;
            bit [31:0] ins, a, b, c, r;
            bit [7:0]  op, fa, fb, fc;
            bit        alu, v, cy;
            res = '{default: 0};
            alu = 0; v = 0; cy = 0; r = 0;
            if (rt == REQ_LOAD) begin
                mem[addr % MEM_WORDS] = word;
                written[addr % MEM_WORDS] = 1;
                pc = base;
                halt = 0;
            end else if (!halt) begin
                ins = mem[pc % MEM_WORDS];
                {op, fa, fb, fc} = ins;
                a = regs[fa[4:0]];
                b = regs[fb[4:0]];
                c = regs[fc[4:0]];
                pc = pc + 1;
                case (op)
                    OP_ADD: begin
                        r = a + b; alu = 1;
                        v = (pos(a) && pos(b) && r[31]) || (a[31] && b[31] && pos(r));
                        cy = sign_carry(a, b, r);
                    end
                    OP_SUB: begin
                        r = a - b; alu = 1;
                        v = (pos(a) && b[31] && r[31]) || (a[31] && pos(b) && pos(r));
                        cy = sign_carry(a, b, r);
                    end
                    OP_CLR:  begin r = 0; alu = 1; end
                    OP_XOR:  begin r = a ^ b; alu = 1; end
                    OP_OR:   begin r = a | b; alu = 1; end
                    OP_NOT:  begin r = ~a; alu = 1; end
                    OP_AND:  begin r = a & b; alu = 1; end
                    OP_ASL, OP_LSL: begin r = (b >= 32) ? 0 : a << b[4:0]; alu = 1; end
                    OP_ASR: begin
                        r = (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
                        alu = 1;
                    end
                    OP_LSR:  begin r = (b >= 32) ? 0 : a >> b[4:0]; alu = 1; end
                    OP_COPY: begin r = a; alu = 1; end
                    OP_LCH: begin
                        res.reg_written = 1; res.dest_reg = fc[4:0];
                        res.dest_value = {ins[23:8], c[15:0]};
                    end
                    OP_LCL: begin
                        res.reg_written = 1; res.dest_reg = fc[4:0];
                        res.dest_value = {c[31:16], ins[23:8]};
                    end
                    OP_LOAD: begin
                        res.reg_written = 1; res.dest_reg = fc[4:0];
                        res.dest_value = mem[a % MEM_WORDS];
                    end
                    OP_STORE: begin
                        mem[c % MEM_WORDS] = a;
                        written[c % MEM_WORDS] = 1;
                    end
                    OP_MULT: begin r = a * b; alu = 1; v = muldiv_ovf(a, b, r); end
                    OP_DIV: begin
                        if (b == 0) r = '1;
                        else begin
                            r = mag(a) / mag(b);
                            if (a[31] != b[31]) r = -r;
                        end
                        alu = 1; v = muldiv_ovf(a, b, r);
                    end
                    OP_POW: begin
                        r = ipow(a, b); alu = 1;
                        v = b[31] || (pos(a) && !pos(r)) ||
                            (a[31] && pos(b) && !b[0] && r[31]) ||
                            (a[31] && pos(b) && b[0] && pos(r));
                    end
                    OP_MOD: begin
                        if (b == 0) r = a;
                        else begin
                            r = mag(a) % mag(b);
                            if (a[31]) r = -r;
                        end
                        res.reg_written = 1; res.dest_reg = fc[4:0]; res.dest_value = r;
                        {fn, fz, fv, fcy} = {1'b0, r == 0, 2'b00};
                    end
                    OP_ADDI: begin
                        r = a + fb; alu = 1;
                        v = pos(a) && fb != 0 && r[31];
                        cy = a[31] && !r[31];
                    end
                    OP_INC, OP_DEC: begin
                        r = (op == OP_INC) ? a + 1 : a - 1;
                        regs[fa[4:0]] = r;
                        alu = 1;
                        v = (op == OP_INC) ? (a == 32'h7FFF_FFFF) : (a == 32'h8000_0000);
                    end
                    OP_LI: begin
                        res.reg_written = 1; res.dest_reg = fc[4:0]; res.dest_value = fa;
                    end
                    OP_BGT: if ($signed(a) > $signed(b)) pc = fc + base;
                    OP_JAL: begin
                        res.reg_written = 1; res.dest_reg = LINK_REG; res.dest_value = pc;
                        pc = ins[15:0] + base;
                    end
                    OP_JR:  pc = regs[LINK_REG][15:0] + base;
                    OP_BEQ: if (a == b) pc = fc + base;
                    OP_BNE: if (a != b) pc = fc + base;
                    OP_J:   pc = ins[15:0] + base;
                    OP_HALT: halt = 1;
                    default: ;
                endcase
                if (alu) begin
                    res.reg_written = 1; res.dest_reg = fc[4:0]; res.dest_value = r;
                    {fn, fz, fv, fcy} = {r[31], r == 0, v, cy};
                end
                if (res.reg_written) regs[res.dest_reg] = res.dest_value;
            end
            res.next_pc = pc;
            {res.neg, res.zero, res.ovf, res.carry, res.halted} = {fn, fz, fv, fcy, halt};
            pending_results.push_back(res);
        endfunction

        function void cmp(string name, bit [31:0] exp_v, bit [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(core_result_t got);
            core_result_t e;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            cmp("next_pc", e.next_pc, got.next_pc);
            cmp("reg_written", e.reg_written, got.reg_written);
            cmp("dest_reg", e.dest_reg, got.dest_reg);
            cmp("dest_value", e.dest_value, got.dest_value);
            cmp("flag_negative", e.neg, got.neg);
            cmp("flag_is_zero", e.zero, got.zero);
            cmp("flag_overflow", e.ovf, got.ovf);
            cmp("flag_carry", e.carry, got.carry);
            cmp("halted", e.halted, got.halted);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel, i_penable, i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    riseu_req_if req_bus();
    riseu_rsp_if rsp_bus();

    risc_instruction_execute_unit #(.MEM_WORDS(MEM_WORDS)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req_bus),
        .o_rsp    (rsp_bus),
        .i_psel   (i_psel),
        .i_penable(i_penable),
        .i_pwrite (i_pwrite),
        .i_paddr  (i_paddr),
        .i_pwdata (i_pwdata),
        .o_prdata (o_prdata),
        .o_pready (o_pready)
    );

    exec_scoreboard sb = new();
    int burst_left;
    int items_sent;

    always #4 i_clk = ~i_clk;

    initial begin
        #120_000_000;
        $display("risc_instruction_execute_unit regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        core_result_t got;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.next_pc     = rsp_bus.next_pc;
            got.reg_written = rsp_bus.reg_written;
            got.dest_reg    = rsp_bus.dest_reg;
            got.dest_value  = rsp_bus.dest_value;
            got.neg         = rsp_bus.flag_negative;
            got.zero        = rsp_bus.flag_is_zero;
            got.ovf         = rsp_bus.flag_overflow;
            got.carry       = rsp_bus.flag_carry;
            got.halted      = rsp_bus.halted;
            sb.check_result(got);
        end
    end

    // result side stalls; one long hold-off to back up the request side
    initial begin
        int mode, len, stretch;
        rsp_bus.ready = 0;
        stretch = 0;
        wait (i_rst_n);
        forever begin
            stretch++;
            if (stretch == 6) begin
                @(posedge i_clk);
                rsp_bus.ready <= 0;
                repeat (400) @(posedge i_clk);
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(1, 40);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: rsp_bus.ready <= 1;
                    1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_bus.ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    task automatic send_item(bit rt, bit [15:0] addr, bit [31:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_bus.valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_bus.valid    <= 1;
        req_bus.req_type <= rt;
        req_bus.mem_addr <= addr;
        req_bus.mem_word <= word;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_request(rt, addr, word);
        items_sent++;
    endtask

    task automatic set_load_base(bit [15:0] value);
        req_bus.valid <= 0;
        burst_left = 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_psel    <= 1;
        i_pwrite  <= 1;
        i_penable <= 0;
        i_paddr   <= ADDR_LOAD_BASE;
        i_pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(posedge i_clk);
        i_penable <= 1;
        @(posedge i_clk);
        sb.base = value;
        i_psel    <= 0;
        i_penable <= 0;
        @(posedge i_clk);
    endtask

    function automatic bit [7:0] pick_reg();
        bit [4:0] r;
        r = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
        return {3'($urandom_range(0, 7)), r};
    endfunction

    function automatic bit [31:0] rand_instr(int n);
        bit [7:0] pool[] = '{OP_ADD, OP_ADD, OP_SUB, OP_SUB, OP_CLR, OP_XOR, OP_OR,
                             OP_NOT, OP_AND, OP_ASL, OP_ASR, OP_LSL, OP_LSR, OP_COPY,
                             OP_LCH, OP_LCH, OP_LCL, OP_LCL, OP_LOAD, OP_STORE, OP_MULT,
                             OP_DIV, OP_MOD, OP_ADDI, OP_INC, OP_DEC, OP_LI, OP_LI,
                             OP_BGT, OP_JAL, OP_JR, OP_BEQ, OP_BNE, OP_J, OP_NOP, OP_POW};
        bit [7:0] op;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2) return {OP_HALT, 24'($urandom)};
        if (sel < 4) return {8'($urandom_range(37, 254)), 24'($urandom)};
        op = pool[$urandom_range(0, pool.size() - 1)];
        case (op)
            OP_LCH, OP_LCL: return {op, 16'($urandom), pick_reg()};
            OP_LI: return {op, 8'($urandom), 8'($urandom), pick_reg()};
            OP_BGT, OP_BEQ, OP_BNE:
                return {op, pick_reg(), pick_reg(), 8'($urandom_range(0, n - 1))};
            OP_JAL, OP_J: return {op, 8'($urandom), 16'($urandom_range(0, n - 1))};
            default: return {op, pick_reg(), pick_reg(), pick_reg()};
        endcase
    endfunction

    task automatic run_program(bit [31:0] prog[$], int max_steps);
        int steps, extra;
        for (int i = 0; i < prog.size(); i++)
            send_item(REQ_LOAD, sb.base + 16'(i), prog[i]);
        steps = 0;
        extra = $urandom_range(0, 2);
        while (steps < max_steps && sb.fetch_ok()) begin
            if (sb.halt) begin
                if (extra == 0) break;
                extra--;
            end
            send_item(REQ_STEP, 16'($urandom), $urandom);
            steps++;
        end
    endtask

    task automatic random_sequence();
        bit [31:0] prog[$];
        bit [7:0]  ar;
        int n;
        if ($urandom_range(0, 3) == 0)
            send_item(REQ_LOAD, 16'($urandom), $urandom);
        n = $urandom_range(4, 24);
        while (prog.size() < n) begin
            if ($urandom_range(0, 6) == 0) begin
                // address pointer, then store through it and load it back
                ar = {3'($urandom_range(0, 7)), 5'($urandom_range(20, 27))};
                prog.push_back({OP_LI, 8'($urandom), 8'($urandom), ar});
                prog.push_back({OP_STORE, pick_reg(), 8'($urandom), ar});
                prog.push_back({OP_LOAD, ar, 8'($urandom), pick_reg()});
            end else begin
                prog.push_back(rand_instr(n));
            end
        end
        run_program(prog, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 60);
    endtask

    initial begin
        bit [31:0]  prog[$];
        bit [15:0]  bases[] = '{16'hFFFF, 16'h0000, 16'hFFF8, 16'h8000, 16'h0123, 16'h7FF0};
        i_clk = 0;
        i_rst_n = 0;
        i_psel = 0;
        i_penable = 0;
        i_pwrite = 0;
        i_paddr = '0;
        i_pwdata = '0;
        req_bus.valid = 0;
        req_bus.req_type = REQ_LOAD;
        req_bus.mem_addr = '0;
        req_bus.mem_word = '0;
        burst_left = 0;
        items_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // corner operands: max, min, -1, and the special arithmetic cases
        prog = '{{OP_LCH, 16'h7FFF, 8'd1}, {OP_LCL, 16'hFFFF, 8'd1},
                 {OP_LCH, 16'h8000, 8'd2}, {OP_LCL, 16'h0000, 8'd2},
                 {OP_LCH, 16'hFFFF, 8'd3}, {OP_LCL, 16'hFFFF, 8'd3},
                 {OP_ADD, 8'd1, 8'd1, 8'd4}, {OP_SUB, 8'd2, 8'd1, 8'd5},
                 {OP_DIV, 8'd2, 8'd3, 8'd6}, {OP_DIV, 8'd1, 8'd0, 8'd7},
                 {OP_MOD, 8'd1, 8'd0, 8'd8}, {OP_ASR, 8'd2, 8'd1, 8'd9},
                 {OP_POW, 8'd3, 8'd3, 8'd10}, {OP_INC, 8'd1, 8'd0, 8'd11},
                 {OP_DEC, 8'd2, 8'd0, 8'd12}, {OP_JAL, 24'd17},
                 {OP_HALT, 24'd0}, {OP_JR, 24'd0}};
        run_program(prog, 30);

        for (int ph = 0; ph < bases.size(); ph++) begin
            set_load_base((ph == 4) ? 16'($urandom) : bases[ph]);
            while (items_sent < (ph + 1) * STEP_ITEMS / bases.size())
                random_sequence();
        end

        req_bus.valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("risc_instruction_execute_unit regression: pass");
        else
            $display("risc_instruction_execute_unit regression: fail");
        $finish;
    end

endmodule
